>>> rtl/core/scpr_pkg.sv
// Shared constants for the second chance page replacer.
// Default sizes, configuration register width and counter width.
// No dependencies.
package scpr_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;
  localparam int unsigned PAGE_BITS_DEF   = 20;

  // table_entries register
  localparam int unsigned CFG_W     = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // running hit and miss totals
  localparam int unsigned TOTAL_W   = 32;

endpackage

>>> rtl/core/second_chance_page_replacer.sv
// Second chance (clock) page replacement table: top level and sequencer.
// Depends on scpr_pkg for default sizes and register widths.
//
// Usage
//   Input channel  : in_valid_i / in_ready_o carries one page_number_i per transaction.
//   Output channel : out_valid_o / out_ready_i carries one result per input transaction:
//                    hit, slot, evicted page (if any) and saturating hit/miss totals.
//   Config         : cfg_we_i writes cfg_wdata_i into table_entries (0 acts as 1,
//                    values above MAX_ENTRIES act as MAX_ENTRIES). Write only while idle.
//   Timing         : the tag search walks the table one entry per cycle through the
//                    single read port of the tag memory and stops early on a hit. A
//                    replacement then sweeps the clock hand past referenced entries,
//                    clearing each set reference bit it passes, and evicts the first
//                    entry whose bit is clear. One item is in flight at a time.
//   Stall          : a finished result waits in the output register; the next item is
//                    accepted and searched meanwhile, and its result is held back until
//                    the output register is free.
//   Reset          : rst_ni (async, active low) clears the valid and reference bits,
//                    the clock hand, both totals and sets table_entries to 64. The tag
//                    memory is not cleared; tags are read only for valid entries.
module second_chance_page_replacer #(
  parameter int unsigned MAX_ENTRIES = scpr_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned PAGE_BITS   = scpr_pkg::PAGE_BITS_DEF,
  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [scpr_pkg::CFG_W-1:0]  cfg_wdata_i,
  // page references
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [PAGE_BITS-1:0]        page_number_i,
  // results
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o,
  output logic [IW-1:0]               slot_o,
  output logic                        evicted_valid_o,
  output logic [PAGE_BITS-1:0]        evicted_page_o,
  output logic [scpr_pkg::TOTAL_W-1:0] hit_total_o,
  output logic [scpr_pkg::TOTAL_W-1:0] miss_total_o
);
  import scpr_pkg::*;

  // NW holds a count 0..MAX_ENTRIES; CW is wide enough to compare it with the register
  localparam int unsigned NW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CW = (NW > CFG_W) ? NW : CFG_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SWEEP,
    S_EVICT,
    S_PUT
  } state_e;

  state_e                 state_q;
  logic [CFG_W-1:0]       cfg_q;
  logic [MAX_ENTRIES-1:0] valid_q;
  logic [MAX_ENTRIES-1:0] ref_q;
  logic [IW-1:0]          hand_q;
  logic [TOTAL_W-1:0]     hits_q;
  logic [TOTAL_W-1:0]     misses_q;

  // per-transaction working registers
  logic [PAGE_BITS-1:0]   page_q;
  logic [NW-1:0]          n_q;
  logic [NW-1:0]          idx_q;
  logic                   pend_q;
  logic [IW-1:0]          pidx_q;
  logic                   free_q;
  logic [IW-1:0]          free_idx_q;
  logic [IW-1:0]          h_q;

  // pending result
  logic                   res_hit_q;
  logic [IW-1:0]          res_slot_q;
  logic                   res_ev_valid_q;
  logic [PAGE_BITS-1:0]   res_ev_page_q;

  // output register
  logic                   out_valid_q;
  logic                   out_hit_q;
  logic [IW-1:0]          out_slot_q;
  logic                   out_ev_valid_q;
  logic [PAGE_BITS-1:0]   out_ev_page_q;

  // tag memory: one write and one registered read per cycle
  logic [PAGE_BITS-1:0]   tag_mem_q [MAX_ENTRIES];
  logic [PAGE_BITS-1:0]   rd_data_q;
  logic [IW-1:0]          rd_addr;
  logic                   mem_we;
  logic [IW-1:0]          mem_wa;

  logic [CW-1:0]          cfg_ext;
  logic [NW-1:0]          n_eff;
  logic                   issue;
  logic                   cmp_hit;
  logic                   cmp_free;
  logic                   last_cmp;
  logic                   free_now;
  logic [IW-1:0]          free_sel;
  logic [NW-1:0]          h_inc;
  logic [IW-1:0]          h_next;
  logic [IW-1:0]          h_start;
  logic                   out_free;

  // Clamp the register into 1..MAX_ENTRIES
  always_comb begin
    cfg_ext = CW'(cfg_q);
    if (cfg_ext == '0) begin
      n_eff = NW'(1);
    end else if (cfg_ext > CW'(MAX_ENTRIES)) begin
      n_eff = NW'(MAX_ENTRIES);
    end else begin
      n_eff = NW'(cfg_ext);
    end
  end

  // Search pipeline: address idx_q issued this cycle, entry pidx_q compared this cycle
  assign issue    = (idx_q != n_q);
  assign cmp_hit  = pend_q && valid_q[pidx_q] && (rd_data_q == page_q);
  assign cmp_free = pend_q && !valid_q[pidx_q];
  assign last_cmp = pend_q && (NW'(pidx_q) == (n_q - NW'(1)));
  assign free_now = free_q || cmp_free;
  assign free_sel = free_q ? free_idx_q : pidx_q;

  // Clock hand arithmetic, wrapping at the active size
  assign h_inc   = NW'(h_q) + NW'(1);
  assign h_next  = (h_inc < n_q) ? IW'(h_inc) : '0;
  assign h_start = (NW'(hand_q) < n_q) ? hand_q : '0;

  assign out_free = !out_valid_q || out_ready_i;

  assign rd_addr = (state_q == S_SWEEP) ? h_q : IW'(idx_q);
  assign mem_we  = ((state_q == S_SEARCH) && !cmp_hit && last_cmp && free_now) ||
                   (state_q == S_EVICT);
  assign mem_wa  = (state_q == S_EVICT) ? h_q : free_sel;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tag_mem_q[mem_wa] <= page_q;
    end
    rd_data_q <= tag_mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      cfg_q          <= CFG_RESET;
      valid_q        <= '0;
      ref_q          <= '0;
      hand_q         <= '0;
      hits_q         <= '0;
      misses_q       <= '0;
      page_q         <= '0;
      n_q            <= '0;
      idx_q          <= '0;
      pend_q         <= 1'b0;
      pidx_q         <= '0;
      free_q         <= 1'b0;
      free_idx_q     <= '0;
      h_q            <= '0;
      res_hit_q      <= 1'b0;
      res_slot_q     <= '0;
      res_ev_valid_q <= 1'b0;
      res_ev_page_q  <= '0;
      out_valid_q    <= 1'b0;
      out_hit_q      <= 1'b0;
      out_slot_q     <= '0;
      out_ev_valid_q <= 1'b0;
      out_ev_page_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      // drop the result once the receiver takes it; S_PUT reloads it itself
      if (out_ready_i && (state_q != S_PUT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            page_q  <= page_number_i;
            n_q     <= n_eff;
            idx_q   <= '0;
            pend_q  <= 1'b0;
            free_q  <= 1'b0;
            state_q <= S_SEARCH;
          end
        end

        S_SEARCH: begin
          pend_q <= issue;
          pidx_q <= IW'(idx_q);
          if (issue) begin
            idx_q <= idx_q + NW'(1);
          end
          if (cmp_hit) begin
            ref_q[pidx_q]  <= 1'b1;
            res_hit_q      <= 1'b1;
            res_slot_q     <= pidx_q;
            res_ev_valid_q <= 1'b0;
            res_ev_page_q  <= '0;
            state_q        <= S_PUT;
          end else begin
            // remember the lowest empty entry
            if (cmp_free && !free_q) begin
              free_q     <= 1'b1;
              free_idx_q <= pidx_q;
            end
            if (last_cmp) begin
              if (free_now) begin
                valid_q[free_sel] <= 1'b1;
                ref_q[free_sel]   <= 1'b0;
                res_hit_q         <= 1'b0;
                res_slot_q        <= free_sel;
                res_ev_valid_q    <= 1'b0;
                res_ev_page_q     <= '0;
                state_q           <= S_PUT;
              end else begin
                h_q     <= h_start;
                state_q <= S_SWEEP;
              end
            end
          end
        end

        // Advance the hand past referenced entries, clearing their bits
        S_SWEEP: begin
          if (ref_q[h_q]) begin
            ref_q[h_q] <= 1'b0;
            h_q        <= h_next;
          end else begin
            state_q <= S_EVICT;
          end
        end

        // rd_data_q now holds the victim's tag; the new tag is written this cycle
        S_EVICT: begin
          ref_q[h_q]     <= 1'b0;
          res_hit_q      <= 1'b0;
          res_slot_q     <= h_q;
          res_ev_valid_q <= 1'b1;
          res_ev_page_q  <= rd_data_q;
          hand_q         <= h_next;
          state_q        <= S_PUT;
        end

        // Hold until the output register is free, then publish and count
        S_PUT: begin
          if (out_free) begin
            out_valid_q    <= 1'b1;
            out_hit_q      <= res_hit_q;
            out_slot_q     <= res_slot_q;
            out_ev_valid_q <= res_ev_valid_q;
            out_ev_page_q  <= res_ev_page_q;
            if (res_hit_q) begin
              hits_q <= (hits_q == '1) ? hits_q : hits_q + TOTAL_W'(1);
            end else begin
              misses_q <= (misses_q == '1) ? misses_q : misses_q + TOTAL_W'(1);
            end
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q;
  assign slot_o          = out_slot_q;
  assign evicted_valid_o = out_ev_valid_q;
  assign evicted_page_o  = out_ev_page_q;
  assign hit_total_o     = hits_q;
  assign miss_total_o    = misses_q;

endmodule

>>> rtl/core/scpr_checker.sv
// Port-level checks for the second chance page replacer, bound to its top level.
// Depends on scpr_pkg for the default page width.
module scpr_checker #(
  parameter int unsigned PAGE_BITS = scpr_pkg::PAGE_BITS_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic                 hit_o,
  input logic                 evicted_valid_o,
  input logic [PAGE_BITS-1:0] evicted_page_o
);
  import scpr_pkg::*;

  // an accepted reference is searched before the next one is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted on consecutive cycles");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !evicted_valid_o)
    else $error("hit reported with an eviction");

  a_no_evict_zero_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_valid_o |-> (evicted_page_o == '0))
    else $error("evicted page non-zero without eviction");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

endmodule

bind second_chance_page_replacer scpr_checker #(.PAGE_BITS(PAGE_BITS)) u_scpr_checker (.*);
